// ----- rtl/websocket_frame_deframer_unmask_top_macros.svh -----
`ifndef WEBSOCKET_FRAME_DEFRAMER_UNMASK_TOP_MACROS_SVH
`define WEBSOCKET_FRAME_DEFRAMER_UNMASK_TOP_MACROS_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define WSD_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked on every rising edge outside reset.
`define WSD_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/wsd_pkg.sv -----
`default_nettype none

package wsd_pkg;

  localparam int unsigned QUEUE_DEPTH = 4;

  localparam logic [6:0] LEN16_CODE = 7'd126;
  localparam logic [6:0] LEN64_CODE = 7'd127;

  typedef enum logic [2:0] {
    PH_B0    = 3'd0,
    PH_B1    = 3'd1,
    PH_EXT16 = 3'd2,
    PH_EXT64 = 3'd3,
    PH_KEY   = 3'd4,
    PH_DATA  = 3'd5
  } wsd_phase_t;

  // One classified result on its way from the parser to the output stage.
  typedef struct packed {
    logic [7:0] data;
    logic [7:0] key_byte;
    logic [3:0] opcode;
    logic       fin;
    logic       empty;
    logic       last;
  } wsd_item_t;

endpackage

`default_nettype wire

// ----- rtl/websocket_frame_deframer_unmask_top.sv -----
// WebSocket frame deframer: takes the received stream one byte per transaction and parses
// each frame header (FIN, opcode, mask bit, 7-bit, 16-bit or 64-bit length, masking key),
// then emits every payload byte unmasked, tagged with opcode and FIN, with tlast on the last
// byte of the frame; a frame of zero length gives one result flagged empty, on its last
// header byte. Header bytes give no result. A byte is accepted every cycle while the result
// queue has room; the parser keeps all frame state in registers and decides each byte as
// it is accepted, so sustained throughput is one byte per clock while the output keeps up.
// A result is written into the queue at the edge that accepts its byte and then loaded into
// the output register once that register is empty or its transaction completes; the queue
// of QUEUE_DEPTH entries absorbs output stalls before the input is held off.
`default_nettype none

module websocket_frame_deframer_unmask_top
  import wsd_pkg::*;
#(
  parameter int unsigned QUEUE_DEPTH_P = QUEUE_DEPTH
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [7:0]  s_tdata,   // [7:0] data_byte
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [15:0]      m_tdata,   // [7:0] payload_byte, [11:8] frame_opcode, [15:12] zero
  output logic [1:0]       m_tuser,   // [0] final_fragment, [1] empty_frame
  output logic             m_tlast
);

  logic      accept;
  logic      push;
  wsd_item_t push_item;
  logic      full;
  logic      pop;
  logic      not_empty;
  wsd_item_t head_item;

  assign s_tready = !full;
  assign accept   = s_tvalid && s_tready;

  wsd_front u_front (
    .clk       (clk),
    .rst       (rst),
    .accept    (accept),
    .data_byte (s_tdata),
    .push      (push),
    .push_item (push_item)
  );

  wsd_queue #(
    .DEPTH (QUEUE_DEPTH_P)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_item (push_item),
    .full      (full),
    .pop       (pop),
    .not_empty (not_empty),
    .head_item (head_item)
  );

  wsd_back u_back (
    .clk        (clk),
    .rst        (rst),
    .item_valid (not_empty),
    .item       (head_item),
    .pop        (pop),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .m_tdata    (m_tdata),
    .m_tuser    (m_tuser),
    .m_tlast    (m_tlast)
  );

endmodule

`default_nettype wire

// ----- rtl/wsd_front.sv -----
`default_nettype none

`include "websocket_frame_deframer_unmask_top_macros.svh"

module wsd_front
  import wsd_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       accept,
  input  wire logic [7:0] data_byte,
  output logic            push,
  output wsd_item_t       push_item
);

  wsd_phase_t  phase, phase_next;
  logic [3:0]  opcode, opcode_next;
  logic        fin, fin_next;
  logic        masked, masked_next;
  logic [63:0] rem, rem_next;
  logic [2:0]  cnt, cnt_next;
  logic [31:0] key, key_next;
  logic [1:0]  kpos, kpos_next;

  logic [63:0] len_val;
  logic [63:0] rem_dec;
  logic        len_done;
  logic        hdr_done;
  logic [7:0]  key_byte;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase  <= PH_B0;
      opcode <= '0;
      fin    <= 1'b0;
      masked <= 1'b0;
      rem    <= '0;
      cnt    <= '0;
      key    <= '0;
      kpos   <= '0;
    end else begin
      phase  <= phase_next;
      opcode <= opcode_next;
      fin    <= fin_next;
      masked <= masked_next;
      rem    <= rem_next;
      cnt    <= cnt_next;
      key    <= key_next;
      kpos   <= kpos_next;
    end
  end

  // Key bytes are applied in the order they arrived: the first one sits in the top byte.
  always_comb begin
    case (kpos)
      2'd0:    key_byte = key[31:24];
      2'd1:    key_byte = key[23:16];
      2'd2:    key_byte = key[15:8];
      default: key_byte = key[7:0];
    endcase
  end

  assign rem_dec = rem - 64'd1;

  always_comb begin
    phase_next  = phase;
    opcode_next = opcode;
    fin_next    = fin;
    masked_next = masked;
    rem_next    = rem;
    cnt_next    = cnt;
    key_next    = key;
    kpos_next   = kpos;
    len_val     = rem;
    len_done    = 1'b0;
    hdr_done    = 1'b0;
    push        = 1'b0;
    push_item   = '{data: 8'd0, key_byte: 8'd0, opcode: opcode, fin: fin,
                    empty: 1'b0, last: 1'b0};

    if (accept) begin
      unique case (phase) inside
        PH_B1: begin
          masked_next = data_byte[7];
          cnt_next    = '0;
          if (data_byte[6:0] == LEN16_CODE) begin
            rem_next   = '0;
            phase_next = PH_EXT16;
          end else if (data_byte[6:0] == LEN64_CODE) begin
            rem_next   = '0;
            phase_next = PH_EXT64;
          end else begin
            len_val  = {57'd0, data_byte[6:0]};
            rem_next = len_val;
            len_done = 1'b1;
          end
        end
        PH_EXT16, PH_EXT64: begin
          len_val  = {rem[55:0], data_byte};
          rem_next = len_val;
          if (cnt >= ((phase == PH_EXT16) ? 3'd1 : 3'd7)) begin
            len_done = 1'b1;
          end else begin
            cnt_next = cnt + 3'd1;
          end
        end
        PH_KEY: begin
          key_next = {key[23:0], data_byte};
          if (cnt >= 3'd3) begin
            hdr_done = 1'b1;
          end else begin
            cnt_next = cnt + 3'd1;
          end
        end
        PH_DATA: begin
          kpos_next          = kpos + 2'd1;
          rem_next           = rem_dec;
          push               = 1'b1;
          push_item.data     = data_byte;
          push_item.key_byte = masked ? key_byte : 8'd0;
          push_item.last     = (rem_dec == 64'd0);
          if (rem_dec == 64'd0) begin
            phase_next = PH_B0;
          end
        end
        default: begin
          fin_next    = data_byte[7];
          opcode_next = data_byte[3:0];
          phase_next  = PH_B1;
        end
      endcase

      if (len_done) begin
        cnt_next = '0;
        if (masked_next) begin
          key_next   = '0;
          phase_next = PH_KEY;
        end else begin
          hdr_done = 1'b1;
        end
      end

      // A frame with no payload reports itself once, on its last header byte.
      if (hdr_done) begin
        cnt_next  = '0;
        kpos_next = '0;
        if (len_val == 64'd0) begin
          push            = 1'b1;
          push_item.empty = 1'b1;
          push_item.last  = 1'b1;
          phase_next      = PH_B0;
        end else begin
          phase_next = PH_DATA;
        end
      end
    end
  end

  `WSD_ASSERT_NOW(a_data_has_length, phase == PH_DATA, rem != 64'd0,
                  "payload phase entered with nothing left to receive")
  `WSD_ASSERT_NOW(a_push_only_on_byte, push, accept, "result produced without a byte")

endmodule

`default_nettype wire

// ----- rtl/wsd_queue.sv -----
`default_nettype none

`include "websocket_frame_deframer_unmask_top_macros.svh"

module wsd_queue
  import wsd_pkg::*;
#(
  parameter int unsigned DEPTH = QUEUE_DEPTH
) (
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire logic      push,
  input  wsd_item_t      push_item,
  output logic           full,
  input  wire logic      pop,
  output logic           not_empty,
  output wsd_item_t      head_item
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  wsd_item_t             slots [DEPTH];
  logic [PTR_W-1:0]      wr_ptr, wr_ptr_next;
  logic [PTR_W-1:0]      rd_ptr, rd_ptr_next;
  logic [CNT_W-1:0]      count, count_next;

  assign full      = (count == CNT_W'(DEPTH));
  assign not_empty = (count != '0);
  assign head_item = slots[rd_ptr];

  always_comb begin
    wr_ptr_next = wr_ptr;
    rd_ptr_next = rd_ptr;
    if (push) begin
      wr_ptr_next = (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
    end
    if (pop) begin
      rd_ptr_next = (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
    end
    count_next = count + CNT_W'(push) - CNT_W'(pop);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr_next;
      rd_ptr <= rd_ptr_next;
      count  <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_item;
    end
  end

  `WSD_ASSERT_NOW(a_no_overflow, push, !full || pop, "queue written while full")
  `WSD_ASSERT_NOW(a_no_underflow, pop, not_empty, "queue read while empty")
  `WSD_ASSERT_NEXT(a_count_tracks, push && !pop, count != '0,
                   "queue count lost a written entry")

endmodule

`default_nettype wire

// ----- rtl/wsd_back.sv -----
`default_nettype none

module wsd_back
  import wsd_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        item_valid,
  input  wsd_item_t        item,
  output logic             pop,
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [15:0]      m_tdata,
  output logic [1:0]       m_tuser,
  output logic             m_tlast
);

  logic       out_valid;
  logic [7:0] out_data;
  logic [3:0] out_opcode;
  logic       out_fin;
  logic       out_empty;
  logic       out_last;

  // The output register reloads when the queue holds an item and the register is empty or its transaction completes.
  assign pop = item_valid && (!out_valid || m_tready);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (pop) begin
      out_valid <= 1'b1;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      out_data   <= item.data ^ item.key_byte;
      out_opcode <= item.opcode;
      out_fin    <= item.fin;
      out_empty  <= item.empty;
      out_last   <= item.last;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = {4'd0, out_opcode, out_data};
  assign m_tuser  = {out_empty, out_fin};
  assign m_tlast  = out_last;

endmodule

`default_nettype wire
